@@ sv/mmsl_pkg.sv @@
// Shared constants and register codes for the minmod slope limiter.
`timescale 1ns / 1ps

package mmsl_pkg;

    localparam int DEFAULT_MAX_LINE    = 1024;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int DIM_W       = 10;
    localparam int SCALE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_BITS   = 8;
    localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_ROWS_IN_USE = 2'd0;
    localparam cfg_index_t REG_COLS_IN_USE = 2'd1;
    localparam cfg_index_t REG_INV_DX      = 2'd2;
    localparam cfg_index_t REG_INV_DY      = 2'd3;

    localparam logic [DIM_W-1:0]   ROWS_RESET   = 10'd1022;
    localparam logic [DIM_W-1:0]   COLS_RESET   = 10'd1022;
    localparam logic [SCALE_W-1:0] INV_DX_RESET = 16'd256;
    localparam logic [SCALE_W-1:0] INV_DY_RESET = 16'd256;

endpackage

@@ sv/mmsl_in_if.sv @@
// Request channel carrying one grid cell into the slope limiter.
`timescale 1ns / 1ps

interface mmsl_in_if #(
    parameter int SAMPLE_BITS = mmsl_pkg::DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] height_sample;
    logic signed [SAMPLE_BITS-1:0] xvel_sample;
    logic signed [SAMPLE_BITS-1:0] yvel_sample;
    logic                          flush_item;

    modport source (
        output valid, height_sample, xvel_sample, yvel_sample, flush_item,
        input  ready
    );

    modport sink (
        input  valid, height_sample, xvel_sample, yvel_sample, flush_item,
        output ready
    );
endinterface

@@ sv/mmsl_out_if.sv @@
// Result channel carrying the limited slopes of one grid cell.
`timescale 1ns / 1ps

interface mmsl_out_if #(
    parameter int SAMPLE_BITS = mmsl_pkg::DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] height_slope_x;
    logic signed [SAMPLE_BITS-1:0] height_slope_y;
    logic signed [SAMPLE_BITS-1:0] xvel_slope_x;
    logic signed [SAMPLE_BITS-1:0] xvel_slope_y;
    logic signed [SAMPLE_BITS-1:0] yvel_slope_x;
    logic signed [SAMPLE_BITS-1:0] yvel_slope_y;
    logic                          x_valid;
    logic                          y_valid;
    logic                          end_of_grid;

    modport source (
        output valid, height_slope_x, height_slope_y, xvel_slope_x, xvel_slope_y,
               yvel_slope_x, yvel_slope_y, x_valid, y_valid, end_of_grid,
        input  ready
    );

    modport sink (
        input  valid, height_slope_x, height_slope_y, xvel_slope_x, xvel_slope_y,
               yvel_slope_x, yvel_slope_y, x_valid, y_valid, end_of_grid,
        output ready
    );
endinterface

@@ sv/minmod_slope_limiter_2d_core.sv @@
// Top level of the two-dimensional minmod slope limiter.
`timescale 1ns / 1ps

// Usage
// in_ch takes the padded grid in raster order, one cell per request: height,
// x velocity and y velocity, plus flush_item. After the last padded row send
// one more row of flush requests to drain the block.
// out_ch gives one result per request except on the first row of a grid;
// results trail the input by one row. x_valid marks interior rows, y_valid
// interior columns, end_of_grid the last cell of the padded grid.
// cfg_wr_en / cfg_index / cfg_data write rows_in_use, cols_in_use, inv_dx and
// inv_dy; write them only while the block is empty.
// Throughput: one request per cycle while out_ch is not stalled. Each request
// passes the input stage, the product stage and the output register in turn.
// The line memory is read at two addresses when a request is accepted.
// Reset clears the counters and the stage valids and loads the register
// defaults; the line memory is not cleared and needs no clearing pass.
// When out_ch stalls, the three stages fill and in_ch.ready drops only once
// all of them hold work.
module minmod_slope_limiter_2d_core #(
    parameter int MAX_LINE    = mmsl_pkg::DEFAULT_MAX_LINE,
    parameter int SAMPLE_BITS = mmsl_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mmsl_in_if.sink                            in_ch,
    mmsl_out_if.source                         out_ch,
    input  logic                               cfg_wr_en,
    input  logic [mmsl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mmsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int LINE_W = $clog2(MAX_LINE);
    localparam int DIM_W  = mmsl_pkg::DIM_W;
    localparam int ROW_W  = DIM_W + 1;
    localparam int CW     = ((DIM_W > LINE_W) ? DIM_W : LINE_W) + 2;
    localparam int TRIO_W = 3 * SB;
    localparam int WORD_W = 2 * TRIO_W;
    localparam int PW     = SB + 18;
    localparam int RW     = PW - 7;
    localparam int SCL_W  = mmsl_pkg::SCALE_W;

    localparam logic signed [RW-1:0] SAT_HI = $signed({{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_LO = $signed({{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}});

    function automatic logic signed [RW-1:0] round_q(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] sum;
        logic [RW-1:0] q;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        sum = mag + PW'(mmsl_pkg::ROUND_HALF);
        q = RW'(sum >> mmsl_pkg::FRAC_BITS);
        round_q = p[PW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [SB-1:0] minmod_sat(input logic signed [RW-1:0] f,
                                                 input logic signed [RW-1:0] b);
        logic signed [RW-1:0] af;
        logic signed [RW-1:0] ab;
        logic signed [RW-1:0] r;
        af = f[RW-1] ? -f : f;
        ab = b[RW-1] ? -b : b;
        priority if ((f < 0 && b > 0) || (f > 0 && b < 0))
            r = '0;
        else if (af < ab)
            r = f;
        else
            r = b;
        if (r > SAT_HI)
            r = SAT_HI;
        else if (r < SAT_LO)
            r = SAT_LO;
        minmod_sat = r[SB-1:0];
    endfunction

    // configuration registers
    logic [DIM_W-1:0] rows_in_use_reg;
    logic [DIM_W-1:0] cols_in_use_reg;
    logic [SCL_W-1:0] inv_dx_reg;
    logic [SCL_W-1:0] inv_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= mmsl_pkg::ROWS_RESET;
            cols_in_use_reg <= mmsl_pkg::COLS_RESET;
            inv_dx_reg      <= mmsl_pkg::INV_DX_RESET;
            inv_dy_reg      <= mmsl_pkg::INV_DY_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mmsl_pkg::REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[DIM_W-1:0];
                mmsl_pkg::REG_COLS_IN_USE: cols_in_use_reg <= cfg_data[DIM_W-1:0];
                mmsl_pkg::REG_INV_DX:      inv_dx_reg      <= cfg_data[SCL_W-1:0];
                mmsl_pkg::REG_INV_DY:      inv_dy_reg      <= cfg_data[SCL_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic in_fire;
    logic mem_we;

    assign out_adv = !out_valid_reg || out_ch.ready;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign in_fire = in_ch.valid && s1_adv;
    assign mem_we  = s1_valid_reg && s2_adv;
    assign in_ch.ready = s1_adv;

    // grid position
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [LINE_W-1:0] col_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_next;
    logic [LINE_W-1:0] col_cnt_next;
    logic [CW-1:0]     icols;
    logic [CW-1:0]     ncols;
    logic [CW-1:0]     col_ext;
    logic [CW-1:0]     c_eff;
    logic [CW-1:0]     c_inc;
    logic [ROW_W-1:0]  nrows;
    logic [ROW_W-1:0]  nrows2;
    logic [ROW_W-1:0]  r_pre;
    logic [ROW_W-1:0]  r_eff;
    logic [ROW_W-1:0]  r_inc;
    logic [ROW_W-1:0]  r_out;
    logic              has_res;
    logic              xv;
    logic              yv;
    logic              last;
    logic              right_ok;
    logic [LINE_W-1:0] rd_addr_lo;
    logic [LINE_W-1:0] rd_addr_hi;

    always_comb
    begin
        icols = (CW'(cols_in_use_reg) > CW'(MAX_LINE - 2)) ? CW'(MAX_LINE - 2)
                                                            : CW'(cols_in_use_reg);
        ncols   = icols + CW'(2);
        nrows   = ROW_W'(rows_in_use_reg);
        nrows2  = nrows + ROW_W'(2);
        col_ext = CW'(col_cnt_reg);
        if (col_ext >= ncols)
        begin
            c_eff = '0;
            r_pre = row_cnt_reg + ROW_W'(1);
        end
        else
        begin
            c_eff = col_ext;
            r_pre = row_cnt_reg;
        end
        r_eff = (r_pre > nrows2) ? '0 : r_pre;
        c_inc = c_eff + CW'(1);
        r_inc = r_eff + ROW_W'(1);
        if (c_inc >= ncols)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r_inc > nrows2) ? '0 : r_inc;
        end
        else
        begin
            col_cnt_next = LINE_W'(c_inc);
            row_cnt_next = r_eff;
        end
        has_res    = r_eff != '0;
        r_out      = r_eff - ROW_W'(1);
        xv         = (r_out >= ROW_W'(1)) && (r_out <= nrows);
        yv         = (c_eff >= CW'(1)) && (c_eff <= icols);
        last       = (r_out == nrows + ROW_W'(1)) && (c_eff == ncols - CW'(1));
        right_ok   = c_inc < ncols;
        rd_addr_lo = LINE_W'(c_eff);
        rd_addr_hi = LINE_W'(c_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // stage 1: request and line memory read
    logic [LINE_W-1:0] s1_col_reg;
    logic              s1_has_res_reg;
    logic              s1_xv_reg;
    logic              s1_yv_reg;
    logic              s1_last_reg;
    logic              s1_right_ok_reg;
    logic              s1_col0_reg;
    logic [TRIO_W-1:0] s1_cur_reg;
    logic [TRIO_W-1:0] cur_in;

    assign cur_in = in_ch.flush_item ? '0
                  : {in_ch.yvel_sample, in_ch.xvel_sample, in_ch.height_sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg      <= LINE_W'(c_eff);
            s1_has_res_reg  <= has_res;
            s1_xv_reg       <= xv;
            s1_yv_reg       <= yv;
            s1_last_reg     <= last;
            s1_right_ok_reg <= right_ok;
            s1_col0_reg     <= c_eff == '0;
            s1_cur_reg      <= cur_in;
        end
    end

    // line memory: each word holds {older row, previous row}
    logic [WORD_W-1:0] line_mem [MAX_LINE];
    logic [WORD_W-1:0] rd_lo_reg;
    logic [WORD_W-1:0] rd_hi_reg;
    logic [WORD_W-1:0] byp_data_reg;
    logic              byp_lo_reg;
    logic              byp_hi_reg;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] lo_word;
    logic [WORD_W-1:0] hi_word;

    assign lo_word   = byp_lo_reg ? byp_data_reg : rd_lo_reg;
    assign hi_word   = byp_hi_reg ? byp_data_reg : rd_hi_reg;
    assign mem_wdata = {lo_word[TRIO_W-1:0], s1_cur_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[s1_col_reg] <= mem_wdata;
        if (in_fire)
        begin
            rd_lo_reg    <= line_mem[rd_addr_lo];
            rd_hi_reg    <= line_mem[rd_addr_hi];
            byp_lo_reg   <= mem_we && (s1_col_reg == rd_addr_lo);
            byp_hi_reg   <= mem_we && (s1_col_reg == rd_addr_hi);
            byp_data_reg <= mem_wdata;
        end
    end

    // left neighbor: centre sample of the previous request
    logic [TRIO_W-1:0] win_left_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_left_reg <= lo_word[TRIO_W-1:0];
    end

    // differences and scaling products
    logic signed [SB-1:0]    cur_s   [3];
    logic signed [SB-1:0]    mid_s   [3];
    logic signed [SB-1:0]    older_s [3];
    logic signed [SB-1:0]    right_s [3];
    logic signed [SB-1:0]    left_s  [3];
    logic signed [SB:0]      diff_f  [6];
    logic signed [SB:0]      diff_b  [6];
    logic signed [PW-1:0]    prod_f  [6];
    logic signed [PW-1:0]    prod_b  [6];
    logic signed [SCL_W:0]   inv_x;
    logic signed [SCL_W:0]   inv_y;

    assign inv_x = $signed({1'b0, inv_dx_reg});
    assign inv_y = $signed({1'b0, inv_dy_reg});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cur_s[k]   = s1_cur_reg[k*SB +: SB];
            mid_s[k]   = lo_word[k*SB +: SB];
            older_s[k] = lo_word[TRIO_W + k*SB +: SB];
            right_s[k] = s1_right_ok_reg ? hi_word[k*SB +: SB] : '0;
            left_s[k]  = s1_col0_reg ? '0 : win_left_reg[k*SB +: SB];
            diff_f[2*k]   = (SB+1)'(cur_s[k]) - (SB+1)'(mid_s[k]);
            diff_b[2*k]   = (SB+1)'(mid_s[k]) - (SB+1)'(older_s[k]);
            diff_f[2*k+1] = (SB+1)'(right_s[k]) - (SB+1)'(mid_s[k]);
            diff_b[2*k+1] = (SB+1)'(mid_s[k]) - (SB+1)'(left_s[k]);
            prod_f[2*k]   = PW'(diff_f[2*k]) * PW'(inv_x);
            prod_b[2*k]   = PW'(diff_b[2*k]) * PW'(inv_x);
            prod_f[2*k+1] = PW'(diff_f[2*k+1]) * PW'(inv_y);
            prod_b[2*k+1] = PW'(diff_b[2*k+1]) * PW'(inv_y);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] s2_prod_f_reg [6];
    logic signed [PW-1:0] s2_prod_b_reg [6];
    logic                 s2_xv_reg;
    logic                 s2_yv_reg;
    logic                 s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_adv)
            s2_valid_reg <= s1_valid_reg && s1_has_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            s2_prod_f_reg <= prod_f;
            s2_prod_b_reg <= prod_b;
            s2_xv_reg     <= s1_xv_reg;
            s2_yv_reg     <= s1_yv_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // round, limit, saturate
    logic [SB-1:0] slope_next [6];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            if ((j % 2 == 0) ? s2_xv_reg : s2_yv_reg)
                slope_next[j] = minmod_sat(round_q(s2_prod_f_reg[j]),
                                           round_q(s2_prod_b_reg[j]));
            else
                slope_next[j] = '0;
        end
    end

    // output register
    logic [SB-1:0] slope_reg [6];
    logic          x_valid_reg;
    logic          y_valid_reg;
    logic          end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            slope_reg   <= slope_next;
            x_valid_reg <= s2_xv_reg;
            y_valid_reg <= s2_yv_reg;
            end_reg     <= s2_last_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.height_slope_x = $signed(slope_reg[0]);
    assign out_ch.height_slope_y = $signed(slope_reg[1]);
    assign out_ch.xvel_slope_x   = $signed(slope_reg[2]);
    assign out_ch.xvel_slope_y   = $signed(slope_reg[3]);
    assign out_ch.yvel_slope_x   = $signed(slope_reg[4]);
    assign out_ch.yvel_slope_y   = $signed(slope_reg[5]);
    assign out_ch.x_valid        = x_valid_reg;
    assign out_ch.y_valid        = y_valid_reg;
    assign out_ch.end_of_grid    = end_reg;

endmodule

@@ sv/mmsl_checker.sv @@
// Port-level assertions for the minmod slope limiter, bound to its top level.
`timescale 1ns / 1ps

module mmsl_checker #(
    parameter int SAMPLE_BITS = mmsl_pkg::DEFAULT_SAMPLE_BITS
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] height_slope_x,
    input logic [SAMPLE_BITS-1:0] height_slope_y,
    input logic [SAMPLE_BITS-1:0] xvel_slope_x,
    input logic [SAMPLE_BITS-1:0] xvel_slope_y,
    input logic [SAMPLE_BITS-1:0] yvel_slope_x,
    input logic [SAMPLE_BITS-1:0] yvel_slope_y,
    input logic                   x_valid,
    input logic                   y_valid,
    input logic                   end_of_grid
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(height_slope_x)
            && $stable(height_slope_y) && $stable(xvel_slope_x) && $stable(xvel_slope_y)
            && $stable(yvel_slope_x) && $stable(yvel_slope_y) && $stable(x_valid)
            && $stable(y_valid) && $stable(end_of_grid))
        else $error("result changed while stalled");

    a_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !x_valid |->
            height_slope_x == '0 && xvel_slope_x == '0 && yvel_slope_x == '0)
        else $error("x slope nonzero on border row");

    a_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !y_valid |->
            height_slope_y == '0 && xvel_slope_y == '0 && yvel_slope_y == '0)
        else $error("y slope nonzero on border column");

    a_end_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_grid |-> !x_valid && !y_valid)
        else $error("last cell not on the border");

endmodule

bind minmod_slope_limiter_2d_core mmsl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mmsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .height_slope_x (out_ch.height_slope_x),
    .height_slope_y (out_ch.height_slope_y),
    .xvel_slope_x   (out_ch.xvel_slope_x),
    .xvel_slope_y   (out_ch.xvel_slope_y),
    .yvel_slope_x   (out_ch.yvel_slope_x),
    .yvel_slope_y   (out_ch.yvel_slope_y),
    .x_valid        (out_ch.x_valid),
    .y_valid        (out_ch.y_valid),
    .end_of_grid    (out_ch.end_of_grid)
);

@@ tb/sv/minmod_slope_limiter_2d_core_test.sv @@
// Self-checking testbench for the 2D minmod slope limiter: raster grids in, limited slopes checked.
`timescale 1ns / 1ps

module minmod_slope_limiter_2d_core_test;

    localparam int SB         = mmsl_pkg::DEFAULT_SAMPLE_BITS;
    localparam int LINE       = mmsl_pkg::DEFAULT_MAX_LINE;
    localparam int DIM_W      = mmsl_pkg::DIM_W;
    localparam int CFG_W      = mmsl_pkg::CFG_DATA_W;
    localparam int IDLE_LIMIT = 4000;

    typedef logic signed [SB-1:0] sample_t;
    typedef logic [2:0][SB-1:0] triple_t;

    typedef struct packed {
        logic [5:0][SB-1:0] slope;
        logic               x_ok;
        logic               y_ok;
        logic               grid_end;
    } slopes_t;

    class slope_scoreboard;
        int unsigned rows_cfg;
        int unsigned cols_cfg;
        int unsigned dx_cfg;
        int unsigned dy_cfg;
        triple_t     prev_line [LINE];
        triple_t     older_line [LINE];
        triple_t     win_left;
        triple_t     win_mid;
        triple_t     win_right;
        int unsigned row_pos;
        int unsigned col_pos;
        slopes_t     slopes_due [$];
        int unsigned errors;
        string       slope_names [6];

        function new();
            rows_cfg = mmsl_pkg::ROWS_RESET;
            cols_cfg = mmsl_pkg::COLS_RESET;
            dx_cfg = mmsl_pkg::INV_DX_RESET;
            dy_cfg = mmsl_pkg::INV_DY_RESET;
            win_left = '0;
            win_mid = '0;
            win_right = '0;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
            slope_names = '{"height_slope_x", "height_slope_y", "xvel_slope_x",
                            "xvel_slope_y", "yvel_slope_x", "yvel_slope_y"};
        endfunction

        function void set_reg(mmsl_pkg::cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                mmsl_pkg::REG_ROWS_IN_USE: rows_cfg = data[DIM_W-1:0];
                mmsl_pkg::REG_COLS_IN_USE: cols_cfg = data[DIM_W-1:0];
                mmsl_pkg::REG_INV_DX:      dx_cfg = data[mmsl_pkg::SCALE_W-1:0];
                mmsl_pkg::REG_INV_DY:      dy_cfg = data[mmsl_pkg::SCALE_W-1:0];
                default:                   ;
            endcase
        endfunction

        function longint scaled(longint d, int unsigned inv);
            longint p;
            longint m;
            p = d * longint'(inv);
            m = (p < 0) ? -p : p;
            m = (m + mmsl_pkg::ROUND_HALF) >>> mmsl_pkg::FRAC_BITS;
            return (p < 0) ? -m : m;
        endfunction

        function longint limited(longint fwd, longint bwd, int unsigned inv);
            longint f;
            longint b;
            longint r;
            longint hi;
            longint lo;
            f = scaled(fwd, inv);
            b = scaled(bwd, inv);
            hi = (longint'(1) << (SB - 1)) - 1;
            lo = -hi - 1;
            if ((f < 0 && b > 0) || (f > 0 && b < 0))
                r = 0;
            else if (((f < 0) ? -f : f) < ((b < 0) ? -b : b))
                r = f;
            else
                r = b;
            if (r > hi)
                r = hi;
            if (r < lo)
                r = lo;
            return r;
        endfunction

        function void note_cell(triple_t pt, bit fl);
            triple_t     cur;
            int unsigned nrows;
            int unsigned icols;
            int unsigned ncols;
            int unsigned r;
            int unsigned c;
            int unsigned ro;
            bit          xv;
            bit          yv;
            longint      mid;
            longint      sx;
            longint      sy;
            slopes_t     res;
            nrows = rows_cfg;
            icols = (cols_cfg > LINE - 2) ? LINE - 2 : cols_cfg;
            ncols = icols + 2;
            r = row_pos;
            c = col_pos;
            if (c >= ncols)
            begin
                c = 0;
                r++;
            end
            if (r > nrows + 2)
                r = 0;
            cur = fl ? '0 : pt;
            win_left = (c == 0) ? '0 : win_mid;
            win_mid = prev_line[c];
            win_right = (c + 1 < ncols) ? prev_line[c + 1] : '0;
            if (r >= 1)
            begin
                ro = r - 1;
                xv = (ro >= 1) && (ro <= nrows);
                yv = (c >= 1) && (c <= icols);
                for (int k = 0; k < 3; k++)
                begin
                    mid = $signed(win_mid[k]);
                    sx = 0;
                    sy = 0;
                    if (xv)
                        sx = limited($signed(cur[k]) - mid, mid - $signed(older_line[c][k]),
                                     dx_cfg);
                    if (yv)
                        sy = limited($signed(win_right[k]) - mid, mid - $signed(win_left[k]),
                                     dy_cfg);
                    res.slope[2*k] = sx[SB-1:0];
                    res.slope[2*k+1] = sy[SB-1:0];
                end
                res.x_ok = xv;
                res.y_ok = yv;
                res.grid_end = (ro == nrows + 1) && (c == ncols - 1);
                slopes_due.push_back(res);
            end
            older_line[c] = prev_line[c];
            prev_line[c] = cur;
            c++;
            if (c >= ncols)
            begin
                c = 0;
                r++;
                if (r > nrows + 2)
                    r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void flag_error(string what, longint want, longint seen);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
        endfunction

        function void check_result(slopes_t got);
            slopes_t want;
            if (slopes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with no request pending: %h", got);
                return;
            end
            want = slopes_due.pop_front();
            for (int i = 0; i < 6; i++)
                if (got.slope[i] !== want.slope[i])
                    flag_error(slope_names[i], $signed(want.slope[i]), $signed(got.slope[i]));
            if (got.x_ok !== want.x_ok)
                flag_error("x_valid", want.x_ok, got.x_ok);
            if (got.y_ok !== want.y_ok)
                flag_error("y_valid", want.y_ok, got.y_ok);
            if (got.grid_end !== want.grid_end)
                flag_error("end_of_grid", want.grid_end, got.grid_end);
        endfunction

        function int unsigned pending();
            return slopes_due.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    mmsl_pkg::cfg_index_t cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mmsl_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    mmsl_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    minmod_slope_limiter_2d_core #(
        .MAX_LINE    (LINE),
        .SAMPLE_BITS (SB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slope_scoreboard sb;
    int unsigned     cells_sent = 0;
    int unsigned     burst_left = 0;
    int unsigned     idle_cycles = 0;
    bit              calm = 1'b1;
    slopes_t         seen;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            seen.slope[0] = out_ch.height_slope_x;
            seen.slope[1] = out_ch.height_slope_y;
            seen.slope[2] = out_ch.xvel_slope_x;
            seen.slope[3] = out_ch.xvel_slope_y;
            seen.slope[4] = out_ch.yvel_slope_x;
            seen.slope[5] = out_ch.yvel_slope_y;
            seen.x_ok = out_ch.x_valid;
            seen.y_ok = out_ch.y_valid;
            seen.grid_end = out_ch.end_of_grid;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[minmod_slope_limiter_2d_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic triple_t triple_of(sample_t h, sample_t u, sample_t v);
        return {v, u, h};
    endfunction

    function automatic sample_t make_sample(int flavor, sample_t base, int ramp);
        if ($urandom_range(0, 9) == 0)
            return sample_t'($urandom);
        case (flavor)
            0: return sample_t'(int'(base) + ramp + int'($urandom_range(0, 6)) - 3);
            1: return sample_t'(int'($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_dim(int unsigned usual, int unsigned rare);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, rare);
        return $urandom_range(0, usual);
    endfunction

    function automatic int unsigned pick_scale();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 65535;
            3: return 256;
            4: return $urandom_range(1, 1024);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic send_cell(input triple_t pt, input bit fl);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.height_sample <= pt[0];
        in_ch.xvel_sample <= pt[1];
        in_ch.yvel_sample <= pt[2];
        in_ch.flush_item <= fl;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_cell(pt, fl);
        cells_sent++;
    endtask

    // drain: drop valid, wait out every pending result plus pipeline depth
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input mmsl_pkg::cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input int unsigned rows, input int unsigned cols,
                             input int unsigned dx, input int unsigned dy);
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        word[DIM_W-1:0] = DIM_W'(rows);
        write_reg(mmsl_pkg::REG_ROWS_IN_USE, word);
        word = CFG_W'($urandom);
        word[DIM_W-1:0] = DIM_W'(cols);
        write_reg(mmsl_pkg::REG_COLS_IN_USE, word);
        write_reg(mmsl_pkg::REG_INV_DX, CFG_W'(dx));
        write_reg(mmsl_pkg::REG_INV_DY, CFG_W'(dy));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_demo_grid();
        triple_t pts [9];
        pts[0] = triple_of(16'sh8000, 16'sd5, 16'sh8000);
        pts[1] = triple_of(16'sd0, -16'sd7, 16'sd0);
        pts[2] = triple_of(16'sh7FFF, 16'sd9, 16'sh7FFF);
        pts[3] = triple_of(16'sd100, 16'sd1, 16'sd0);
        pts[4] = triple_of(16'sd200, -16'sd3, 16'sd1);
        pts[5] = triple_of(16'sd300, 16'sd2, -16'sd1);
        pts[6] = triple_of(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        pts[7] = triple_of(16'sd400, 16'sh7FFF, 16'sh8000);
        pts[8] = triple_of(16'sh8000, 16'sd0, 16'sd0);
        for (int i = 0; i < 9; i++)
            send_cell(pts[i], i == 8);
        // flush row with an ordinary request in the middle
        for (int c = 0; c < 3; c++)
            send_cell(triple_of(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom)),
                      c != 1);
    endtask

    task automatic run_grid();
        int unsigned nrows;
        int unsigned ncols;
        int          flavor;
        sample_t     base [3];
        int          grad_c [3];
        int          grad_r [3];
        triple_t     pt;
        bit          fl;
        nrows = sb.rows_cfg;
        ncols = ((sb.cols_cfg > LINE - 2) ? LINE - 2 : sb.cols_cfg) + 2;
        flavor = $urandom_range(0, 3);
        for (int k = 0; k < 3; k++)
        begin
            base[k] = sample_t'($urandom);
            grad_c[k] = int'($urandom_range(0, 600)) - 300;
            grad_r[k] = int'($urandom_range(0, 600)) - 300;
        end
        for (int r = 0; r < nrows + 3; r++)
            for (int c = 0; c < ncols; c++)
            begin
                if (r == nrows + 2)
                    fl = ($urandom_range(0, 7) != 0);
                else
                    fl = ($urandom_range(0, 29) == 0);
                for (int k = 0; k < 3; k++)
                    pt[k] = make_sample(flavor, base[k], grad_c[k] * c + grad_r[k] * r);
                send_cell(pt, fl);
            end
    endtask

    initial
    begin
        sb = new();
        in_ch.valid <= 1'b0;
        in_ch.height_sample <= '0;
        in_ch.xvel_sample <= '0;
        in_ch.yvel_sample <= '0;
        in_ch.flush_item <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= mmsl_pkg::REG_ROWS_IN_USE;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(1, 1, mmsl_pkg::INV_DX_RESET, mmsl_pkg::INV_DY_RESET);
        run_demo_grid();
        settle();
        configure(1, 1, 65535, 0);
        run_demo_grid();

        while (cells_sent < 720)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            configure(pick_dim(8, 16), pick_dim(12, 24), pick_scale(), pick_scale());
            repeat ($urandom_range(1, 2)) run_grid();
        end

        settle();
        calm = 1'b0;
        configure(0, 0, pick_scale(), pick_scale());
        run_grid();
        settle();
        configure(0, 30, pick_scale(), pick_scale());
        run_grid();
        settle();
        configure(30, 0, pick_scale(), pick_scale());
        run_grid();

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[minmod_slope_limiter_2d_core] OK");
        else
            $display("[minmod_slope_limiter_2d_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mmsl_pkg.sv
sv/mmsl_in_if.sv
sv/mmsl_out_if.sv
sv/minmod_slope_limiter_2d_core.sv
sv/mmsl_checker.sv
tb/sv/minmod_slope_limiter_2d_core_test.sv
